// ----- rtl/vks_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vks_pkg;

	// Key array geometry.
	localparam int NUM_KEYS        = 64;
	localparam int NUM_BANKS       = 8;
	localparam int FIRST_TIMED_KEY = 3;

	// Field widths fixed by the interface.
	localparam int LANES    = 8;
	localparam int LANE_W   = 3;
	localparam int BANK_W   = 3;
	localparam int TIMER_W  = 8;
	localparam int KEY_W    = 6;
	localparam int CMP_W    = 9;

	// A bank number can only reach 2**BANK_W rows, so no more rows are stored.
	localparam int ROWS  = (NUM_BANKS < (1 << BANK_W)) ? NUM_BANKS : (1 << BANK_W);
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [TIMER_W-1:0] RELOAD_RESET = 8'd255;

	// One request's worth of pending messages, handed from front to back.
	typedef struct packed {
		logic [BANK_W-1:0]                bank;
		logic [LANES-1:0]                 mask;
		logic [LANES-1:0]                 on;
		logic [LANES-1:0][TIMER_W-1:0]    times;
	} vks_entry_t;

endpackage

`default_nettype wire

// ----- rtl/vks_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vks_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  vks_pkg::vks_entry_t push_data,
	output logic                full,
	input  wire                 pop,
	output logic                not_empty,
	output vks_pkg::vks_entry_t pop_data
);
	import vks_pkg::*;

	vks_entry_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/vks_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vks_front (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire                             op,
	input  wire  [vks_pkg::BANK_W-1:0]      bank,
	input  wire  [vks_pkg::LANES-1:0]       down_contact,
	input  wire  [vks_pkg::LANES-1:0]       up_contact,
	input  wire                             cfg_write,
	input  wire  [vks_pkg::TIMER_W-1:0]     cfg_data,
	input  wire                             q_full,
	output logic                            q_push,
	output vks_pkg::vks_entry_t             q_data
);
	import vks_pkg::*;

	logic [LANES-1:0]               key_down_q [ROWS];
	logic [LANES-1:0][TIMER_W-1:0]  timer_q    [ROWS];
	logic [TIMER_W-1:0]             reload_q;

	logic [ROW_W-1:0]               row_idx;
	logic                           bank_ok;
	logic                           accept;
	logic [LANES-1:0]               s_row;
	logic [LANES-1:0][TIMER_W-1:0]  t_row;
	logic [LANES-1:0]               key_ok;
	logic [LANES-1:0]               go_on;
	logic [LANES-1:0]               go_off;
	logic [LANES-1:0]               emit;
	logic [LANES-1:0]               reload;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign row_idx  = bank[ROW_W-1:0];
	assign bank_ok  = (32'(bank) < 32'(NUM_BANKS));
	assign s_row    = key_down_q[row_idx];
	assign t_row    = timer_q[row_idx];

	// Classify each key of the bank from its state bit and its two contacts.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			key_ok[l] = bank_ok && !op &&
			            (CMP_W'({bank, LANE_W'(l)}) < CMP_W'(NUM_KEYS));
			go_on[l]  = key_ok[l] && !s_row[l] &&  up_contact[l] && !down_contact[l];
			go_off[l] = key_ok[l] &&  s_row[l] && !up_contact[l] &&  down_contact[l];
			reload[l] = key_ok[l] &&
			            ((!s_row[l] && !up_contact[l] &&  down_contact[l]) ||
			             ( s_row[l] &&  up_contact[l] && !down_contact[l]));
		end
		emit = go_on | go_off;
	end

	assign q_push       = accept && (emit != '0);
	assign q_data.bank  = bank;
	assign q_data.mask  = emit;
	assign q_data.on    = go_on;
	assign q_data.times = t_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				key_down_q[r] <= '0;
				timer_q[r]    <= '0;
			end
			reload_q <= RELOAD_RESET;
		end else begin
			if (cfg_write) begin
				reload_q <= cfg_data;
			end
			if (accept && op) begin
				// Scan-end tick: every timed key counts down, holding at zero.
				for (int r = 0; r < ROWS; r++) begin
					for (int l = 0; l < LANES; l++) begin
						if ((r * LANES + l >= FIRST_TIMED_KEY) && (timer_q[r][l] != '0)) begin
							timer_q[r][l] <= timer_q[r][l] - 1'b1;
						end
					end
				end
			end else if (accept) begin
				key_down_q[row_idx] <= s_row ^ emit;
				for (int l = 0; l < LANES; l++) begin
					if (reload[l]) begin
						timer_q[row_idx][l] <= reload_q;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/vks_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vks_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_not_empty,
	input  vks_pkg::vks_entry_t          q_data,
	output logic                         q_pop,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [vks_pkg::KEY_W-1:0]    key_index,
	output logic                         key_on,
	output logic [vks_pkg::TIMER_W-1:0]  flight_time,
	output logic                         last
);
	import vks_pkg::*;

	vks_entry_t         cur_q;
	logic [LANES-1:0]   rem_q;
	logic               busy_q;

	logic [LANES-1:0]   pick;
	logic [LANE_W-1:0]  lane;
	logic               fire;

	// Lowest pending key goes out first, matching ascending bit order.
	assign pick = rem_q & (~rem_q + 1'b1);

	always_comb begin
		lane = '0;
		for (int l = 0; l < LANES; l++) begin
			if (pick[l]) begin
				lane = LANE_W'(l);
			end
		end
	end

	assign out_valid   = busy_q;
	assign key_index   = {cur_q.bank, lane};
	assign key_on      = cur_q.on[lane];
	assign flight_time = cur_q.times[lane];
	assign last        = ((rem_q & ~pick) == '0);
	assign fire        = out_valid && out_ready;
	assign q_pop       = q_not_empty && (!busy_q || (fire && last));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				rem_q  <= q_data.mask;
			end else if (fire) begin
				rem_q <= rem_q & ~pick;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/velocity_keyboard_scanner_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Velocity keyboard scanner for a two-contact key matrix. Each request is either
// a bank sample (op = 0) carrying the down-bar and up-bar contact bits of one bank
// of eight keys, or a scan-end tick (op = 1) that counts down every key's flight
// timer from key FIRST_TIMED_KEY upward, holding at zero. A sample whose contacts
// complete a key press or release yields one message per such key, in ascending
// key order, with the key's flight timer as it stood before the request; the
// last message of a request has last set. The front end takes one request every
// cycle while the queue is not full and updates key state and timers at once; a
// two-entry queue then holds the pending messages of up to two samples. The
// message emitter drains them at one message per cycle while out_ready is high;
// a sample yields up to eight messages, while ticks and samples without messages
// put nothing in the queue. The input stalls only when both queue entries are
// taken. The reload value that starts a flight timer is written through the
// configuration port, which is always ready, and resets to 255.

module velocity_keyboard_scanner_top (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire                             op,
	input  wire  [vks_pkg::BANK_W-1:0]      bank,
	input  wire  [vks_pkg::LANES-1:0]       down_contact,
	input  wire  [vks_pkg::LANES-1:0]       up_contact,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [vks_pkg::KEY_W-1:0]       key_index,
	output logic                            key_on,
	output logic [vks_pkg::TIMER_W-1:0]     flight_time,
	output logic                            last,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [vks_pkg::TIMER_W-1:0]     cfg_data
);
	import vks_pkg::*;

	vks_entry_t  push_data;
	vks_entry_t  pop_data;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_not_empty;

	// Configuration writes land in a single register and never stall.
	assign cfg_ready = 1'b1;

	vks_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.bank         (bank),
		.down_contact (down_contact),
		.up_contact   (up_contact),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (push_data)
	);

	vks_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (pop_data)
	);

	vks_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_index   (key_index),
		.key_on      (key_on),
		.flight_time (flight_time),
		.last        (last)
	);

endmodule

`default_nettype wire
